@@ rtl/core/curvature_path_log_weight_defines.svh @@
// Assertion macros for the curvature path log-weight block.
`ifndef CURVATURE_PATH_LOG_WEIGHT_DEFINES_SVH
`define CURVATURE_PATH_LOG_WEIGHT_DEFINES_SVH
`ifndef SYNTH
`define CPLW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CPLW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CPLW_ASSERT_NOW(label, ante, cons, msg)
`define CPLW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/cplw_pkg.sv @@
// Shared widths and constants of the curvature path log-weight block.
package cplw_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int INDEX_SPACE     = 256;
    localparam int CURV_W          = 32;
    localparam int WEIGHT_W        = 32;
    localparam int INDEX_W         = 8;
    localparam int SUM_W           = 48;
    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;
    localparam logic [2:0] REG_MIN_CURV  = 3'd0;
    localparam logic [2:0] REG_MAX_CURV  = 3'd1;
    localparam logic [2:0] REG_STEP_RECP = 3'd2;
    localparam logic [2:0] REG_LOSS      = 3'd3;
    localparam logic [2:0] REG_ENTRIES   = 3'd4;
endpackage

@@ rtl/core/cplw_item_if.sv @@
// Input channel: table loads and curvature samples.
interface cplw_item_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [cplw_pkg::INDEX_W-1:0]        table_index;
    logic [cplw_pkg::WEIGHT_W-1:0]       table_value;
    logic signed [cplw_pkg::CURV_W-1:0]  curvature;
    logic                                last_sample;

    modport source (output valid, opcode, table_index, table_value, curvature, last_sample,
                    input ready);
    modport sink (input valid, opcode, table_index, table_value, curvature, last_sample,
                  output ready);
endinterface

@@ rtl/core/cplw_result_if.sv @@
// Output channel: one summed path log-weight per path.
interface cplw_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [cplw_pkg::SUM_W-1:0]  path_log10_weight;
    logic                               status;
    logic                               clamped;

    modport source (output valid, path_log10_weight, status, clamped, input ready);
    modport sink (input valid, path_log10_weight, status, clamped, output ready);
endinterface

@@ rtl/core/curvature_path_log_weight.sv @@
// A load transfer writes one weight table entry. For a sample, the log2 normalize
// shifts out the leading zeros of the 64-bit product weight*loss one bit per cycle and
// the mantissa is squared once per cycle for 16 fraction bits; a zero product, or a
// path already pinned to zero, skips both. A sample that ends a path passes S_OUT to
// hand the sum to the output register (S_OUT stalls while it is full); the next
// transfer is taken while the result waits there. The table is one memory with two
// registered read ports.
`include "curvature_path_log_weight_defines.svh"

module curvature_path_log_weight #(
    parameter int TABLE_DEPTH = cplw_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cplw_item_if.sink     item,
    cplw_result_if.source result
);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIMIT = (TABLE_DEPTH < cplw_pkg::INDEX_SPACE) ? TABLE_DEPTH
                                                                 : cplw_pkg::INDEX_SPACE;
    localparam int SW    = cplw_pkg::SUM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_Q    = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_WL   = 4'd3;
    localparam logic [3:0] S_WR   = 4'd4;
    localparam logic [3:0] S_W    = 4'd5;
    localparam logic [3:0] S_P    = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_NORM = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_LOG  = 4'd10;
    localparam logic [3:0] S_RND  = 4'd11;
    localparam logic [3:0] S_ACC  = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    // configuration registers
    logic signed [31:0] min_curv_reg, max_curv_reg;
    logic [31:0]        step_recp_reg, loss_reg;
    logic [8:0]         entries_reg;

    // control
    logic [3:0]  state_reg, state_next;
    logic        last_reg;
    logic        zero_path_reg;
    logic [3:0]  iter_reg;
    logic [5:0]  exp_reg;

    // accumulation state
    logic signed [SW-1:0] sum_reg;
    logic                 zero_seen_reg, clamp_seen_reg;

    // datapath
    logic [31:0]  dist_reg;
    logic [63:0]  q_reg;
    logic [15:0]  f_reg;
    logic [31:0]  rdl_reg, rdr_reg;
    logic [48:0]  pl_reg;
    logic [47:0]  pr_reg;
    logic [31:0]  w_reg;
    logic [63:0]  p_reg;
    logic [63:0]  norm_reg;
    logic [31:0]  y_reg;
    logic [15:0]  frac_reg;
    logic [53:0]  lprod_reg;
    logic         lneg_reg;
    logic signed [22:0] log10_reg;

    // output register
    logic                 out_valid_reg;
    logic signed [SW-1:0] out_sum_reg;
    logic                 out_status_reg, out_clamped_reg;

    // table memory
    logic [31:0] mem [TABLE_DEPTH];

    logic cfg_wr;
    logic item_xfer;
    logic out_free;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign item.ready = (state_reg == S_IDLE);
    assign item_xfer = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;

    assign result.valid             = out_valid_reg;
    assign result.path_log10_weight = out_sum_reg;
    assign result.status            = out_status_reg;
    assign result.clamped           = out_clamped_reg;

    // register read-back
    always_comb
    begin
        case (paddr[4:2])
            cplw_pkg::REG_MIN_CURV:  prdata = min_curv_reg;
            cplw_pkg::REG_MAX_CURV:  prdata = max_curv_reg;
            cplw_pkg::REG_STEP_RECP: prdata = step_recp_reg;
            cplw_pkg::REG_LOSS:      prdata = loss_reg;
            cplw_pkg::REG_ENTRIES:   prdata = {23'd0, entries_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_curv_reg  <= '0;
            max_curv_reg  <= '0;
            step_recp_reg <= 32'd65536;
            loss_reg      <= 32'h8000_0000;
            entries_reg   <= 9'd256;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                cplw_pkg::REG_MIN_CURV:  min_curv_reg  <= pwdata;
                cplw_pkg::REG_MAX_CURV:  max_curv_reg  <= pwdata;
                cplw_pkg::REG_STEP_RECP: step_recp_reg <= pwdata;
                cplw_pkg::REG_LOSS:      loss_reg      <= pwdata;
                cplw_pkg::REG_ENTRIES:   entries_reg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // clamp and offset of the incoming curvature
    logic signed [31:0] c_lo, c_hi;
    logic signed [32:0] dist_s;
    logic               clamp_hit;
    always_comb
    begin
        c_lo      = (item.curvature < min_curv_reg) ? min_curv_reg : item.curvature;
        c_hi      = (c_lo > max_curv_reg) ? max_curv_reg : c_lo;
        clamp_hit = (item.curvature < min_curv_reg) || (c_lo > max_curv_reg);
        dist_s    = 33'(c_hi) - 33'(min_curv_reg);
    end

    // neighbor selection
    logic [8:0]    n_eff, n_m1, left9, right9;
    logic [15:0]   f_sel;
    logic [AW-1:0] addr_l, addr_r;
    always_comb
    begin
        if (entries_reg < 9'd2)
            n_eff = 9'd2;
        else if (entries_reg > 9'(LIMIT))
            n_eff = 9'(LIMIT);
        else
            n_eff = entries_reg;
        n_m1 = n_eff - 9'd1;
        if (q_reg[63:32] >= {23'd0, n_m1})
        begin
            left9  = n_m1;
            right9 = n_m1;
            f_sel  = 16'd0;
        end
        else
        begin
            left9  = q_reg[40:32];
            right9 = q_reg[40:32] + 9'd1;
            f_sel  = q_reg[31:16];
        end
        addr_l = AW'(left9);
        addr_r = AW'(right9);
    end

    // memory: load port and two read ports
    always_ff @(posedge clk)
    begin
        if (item_xfer && item.opcode == cplw_pkg::OP_LOAD
            && 32'(item.table_index) < TABLE_DEPTH)
            mem[AW'(item.table_index)] <= item.table_value;
        rdl_reg <= mem[addr_l];
        rdr_reg <= mem[addr_r];
    end

    // squaring step and log conversion pieces
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [31:0] loss_eff;
    logic signed [23:0] l2;
    logic [22:0] l2_mag;
    logic [54:0] lround;
    logic signed [22:0] r_signed;
    logic signed [SW:0] acc_sum;
    always_comb
    begin
        sq       = 64'(y_reg) * 64'(y_reg);
        sq_sh    = sq[63:31];
        loss_eff = (loss_reg > 32'h8000_0000) ? 32'h8000_0000 : loss_reg;
        l2       = ((24'(exp_reg) - 24'sd55) <<< 16) + 24'(frac_reg);
        l2_mag   = l2[23] ? 23'(-l2) : l2[22:0];
        lround   = 55'(lprod_reg) + 55'h8000_0000;
        r_signed = lneg_reg ? -$signed({1'b0, lround[53:32]}) : $signed({1'b0, lround[53:32]});
        acc_sum  = $signed({sum_reg[SW-1], sum_reg}) + (SW+1)'(log10_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (item_xfer && item.opcode == cplw_pkg::OP_SAMPLE) state_next = S_Q;
            S_Q:    state_next = S_ADDR;
            S_ADDR: state_next = S_WL;
            S_WL:   state_next = S_WR;
            S_WR:   state_next = S_W;
            S_W:    state_next = S_P;
            S_P:    state_next = S_CHK;
            S_CHK:  state_next = (p_reg == 64'd0 || zero_seen_reg) ? S_ACC : S_NORM;
            S_NORM: if (norm_reg[63]) state_next = S_SQ;
            S_SQ:   if (iter_reg == 4'd15) state_next = S_LOG;
            S_LOG:  state_next = S_RND;
            S_RND:  state_next = S_ACC;
            S_ACC:  state_next = last_reg ? S_OUT : S_IDLE;
            S_OUT:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and accumulation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sum_reg        <= '0;
            zero_seen_reg  <= 1'b0;
            clamp_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            iter_reg       <= '0;
            exp_reg        <= '0;
            zero_path_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (item_xfer && item.opcode == cplw_pkg::OP_SAMPLE)
                    begin
                        last_reg <= item.last_sample;
                        if (clamp_hit)
                            clamp_seen_reg <= 1'b1;
                    end
                end
                S_CHK:
                begin
                    zero_path_reg <= (p_reg == 64'd0) || zero_seen_reg;
                    exp_reg       <= 6'd63;
                end
                S_NORM:
                begin
                    iter_reg <= '0;
                    if (!norm_reg[63])
                        exp_reg <= exp_reg - 6'd1;
                end
                S_SQ:    iter_reg <= iter_reg + 4'd1;
                S_ACC:
                begin
                    if (zero_path_reg)
                    begin
                        zero_seen_reg <= 1'b1;
                        sum_reg       <= cplw_pkg::SUM_MIN;
                    end
                    else if (acc_sum > $signed({1'b0, cplw_pkg::SUM_MAX}))
                        sum_reg <= cplw_pkg::SUM_MAX;
                    else if (acc_sum < $signed({1'b1, cplw_pkg::SUM_MIN}))
                        sum_reg <= cplw_pkg::SUM_MIN;
                    else
                        sum_reg <= acc_sum[SW-1:0];
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        sum_reg        <= '0;
                        zero_seen_reg  <= 1'b0;
                        clamp_seen_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE: dist_reg <= dist_s[32] ? 32'd0 : dist_s[31:0];
            S_Q:    q_reg <= 64'(dist_reg) * 64'(step_recp_reg);
            S_ADDR: f_reg <= f_sel;
            S_WL:   pl_reg <= 49'(rdl_reg) * 49'(17'h10000 - 17'(f_reg));
            S_WR:   pr_reg <= 48'(rdr_reg) * 48'(f_reg);
            S_W:    w_reg <= 32'((50'(pl_reg) + 50'(pr_reg)) >> 16);
            S_P:    p_reg <= 64'(w_reg) * 64'(loss_eff);
            S_CHK:
            begin
                norm_reg <= p_reg;
                frac_reg <= '0;
            end
            S_NORM:
            begin
                if (norm_reg[63])
                    y_reg <= norm_reg[63:32];
                else
                    norm_reg <= norm_reg << 1;
            end
            S_SQ:
            begin
                frac_reg <= {frac_reg[14:0], sq_sh[32]};
                y_reg    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
            end
            S_LOG:
            begin
                lprod_reg <= 54'(l2_mag) * 54'(cplw_pkg::LOG10_2_Q32);
                lneg_reg  <= l2[23];
            end
            S_RND:  log10_reg <= r_signed;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_sum_reg     <= sum_reg;
                    out_status_reg  <= zero_seen_reg;
                    out_clamped_reg <= clamp_seen_reg;
                end
            end
            default: ;
        endcase
    end

    // checks
    `CPLW_ASSERT_NOW(a_mant_norm, state_reg == S_SQ, y_reg[31], "mantissa lost its leading one")
    `CPLW_ASSERT_NOW(a_zero_sum, zero_seen_reg, sum_reg == cplw_pkg::SUM_MIN, "zero weight sum not pinned")
    `CPLW_ASSERT_NOW(a_norm_nz, state_reg == S_NORM, norm_reg != 64'd0, "normalize on zero product")
endmodule
